// ===== rtl/dcc_pkg.sv =====
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared sizes, request codes and command structs for the dynamic
// connected components block.
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int MAX_V  = 16;
  localparam int VID_W  = $clog2(MAX_V);
  localparam int CNT_W  = $clog2(MAX_V + 1);
  localparam int EDGE_W = 8;
  localparam int REQ_W  = 2;

  // Request codes (any other code acts as a query)
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  // Configuration register map: index taken from address bit 2
  localparam int  APB_ADDR_W  = 3;
  localparam int  APB_DATA_W  = 32;
  localparam logic REG_VIN    = 1'b0;

  typedef logic [MAX_V-1:0]  row_t;
  typedef logic [VID_W-1:0]  vid_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [EDGE_W-1:0] edge_cnt_t;

  // Adjacency memory access: one read, one write a cycle
  typedef struct packed {
    vid_t rd_addr;
    logic wr_en;
    vid_t wr_addr;
    row_t wr_data;
  } adj_cmd_t;

  // Label memory access: two reads, one write a cycle
  typedef struct packed {
    vid_t rd_a_addr;
    vid_t rd_b_addr;
    logic wr_en;
    vid_t wr_addr;
    vid_t wr_data;
  } lbl_cmd_t;

  // Configuration seen by the core
  typedef struct packed {
    logic clr;
    cnt_t vin;
    cnt_t vin_new;
  } cfg_t;

endpackage

// ===== rtl/dcc_intf.sv =====
// ----------------------------------------------------------------------------
// dcc_in_if / dcc_out_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface dcc_in_if;
  logic                              valid;
  logic                              ready;
  logic [dcc_pkg::REQ_W-1:0]         req_type;
  logic [3:0]                        vertex_a;
  logic [3:0]                        vertex_b;

  modport source (output valid, req_type, vertex_a, vertex_b, input ready);
  modport sink   (input valid, req_type, vertex_a, vertex_b, output ready);
endinterface

interface dcc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              same_component;
  logic [4:0]                        component_count;
  logic [7:0]                        edge_count;
  logic                              bad_vertex;

  modport source (output valid, same_component, component_count, edge_count, bad_vertex,
                  input ready);
  modport sink   (input valid, same_component, component_count, edge_count, bad_vertex,
                  output ready);
endinterface

// ===== rtl/dcc_adj_mem.sv =====
// ----------------------------------------------------------------------------
// dcc_adj_mem
// Adjacency matrix memory, one row per vertex, registered read. Rows that
// were not written since the last clear read as zero.
// ----------------------------------------------------------------------------
module dcc_adj_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  dcc_pkg::adj_cmd_t cmd,
  output dcc_pkg::row_t     rd_row
);

  dcc_pkg::row_t mem [dcc_pkg::MAX_V];
  dcc_pkg::row_t vld_r;
  dcc_pkg::row_t rd_data_r;
  logic          rd_vld_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    rd_data_r <= mem[cmd.rd_addr];
    rd_vld_r  <= vld_r[cmd.rd_addr];
  end

  // Row valid bits, dropped on reset and clear
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (cmd.wr_en) begin
      vld_r[cmd.wr_addr] <= 1'b1;
    end
  end

  assign rd_row = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== rtl/dcc_lbl_mem.sv =====
// ----------------------------------------------------------------------------
// dcc_lbl_mem
// Component label memory, two registered read ports and one write port.
// Entries not written since the last clear read as their own vertex index.
// ----------------------------------------------------------------------------
module dcc_lbl_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  dcc_pkg::lbl_cmd_t cmd,
  output dcc_pkg::vid_t     rd_a,
  output dcc_pkg::vid_t     rd_b
);

  dcc_pkg::vid_t mem [dcc_pkg::MAX_V];
  dcc_pkg::row_t vld_r;
  dcc_pkg::vid_t rd_a_data_r;
  dcc_pkg::vid_t rd_b_data_r;
  dcc_pkg::vid_t rd_a_addr_r;
  dcc_pkg::vid_t rd_b_addr_r;
  logic          rd_a_vld_r;
  logic          rd_b_vld_r;

  // Write and registered reads
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    rd_a_data_r <= mem[cmd.rd_a_addr];
    rd_b_data_r <= mem[cmd.rd_b_addr];
    rd_a_addr_r <= cmd.rd_a_addr;
    rd_b_addr_r <= cmd.rd_b_addr;
    rd_a_vld_r  <= vld_r[cmd.rd_a_addr];
    rd_b_vld_r  <= vld_r[cmd.rd_b_addr];
  end

  // Entry valid bits, dropped on reset and clear
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (cmd.wr_en) begin
      vld_r[cmd.wr_addr] <= 1'b1;
    end
  end

  assign rd_a = rd_a_vld_r ? rd_a_data_r : rd_a_addr_r;
  assign rd_b = rd_b_vld_r ? rd_b_data_r : rd_b_addr_r;

endmodule

// ===== rtl/dcc_core.sv =====
// ----------------------------------------------------------------------------
// dcc_core
// Request sequencer: reads, modifies and writes back the adjacency and
// label memories, keeps the counts and drives the result register.
// ----------------------------------------------------------------------------
module dcc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  dcc_pkg::cfg_t     cfg,
  dcc_in_if.sink            in_ch,
  dcc_out_if.source         out_ch,
  output dcc_pkg::adj_cmd_t adj_cmd,
  input  dcc_pkg::row_t     adj_row,
  output dcc_pkg::lbl_cmd_t lbl_cmd,
  input  dcc_pkg::vid_t     lbl_a,
  input  dcc_pkg::vid_t     lbl_b
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDA   = 4'd1;
  localparam logic [3:0] S_WRA   = 4'd2;
  localparam logic [3:0] S_RDB   = 4'd3;
  localparam logic [3:0] S_WRB   = 4'd4;
  localparam logic [3:0] S_MRG   = 4'd5;
  localparam logic [3:0] S_RSEL  = 4'd6;
  localparam logic [3:0] S_REXP  = 4'd7;
  localparam logic [3:0] S_RROW  = 4'd8;
  localparam logic [3:0] S_RDONE = 4'd9;
  localparam logic [3:0] S_RSAME = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  function automatic dcc_pkg::row_t onehot(input dcc_pkg::vid_t i);
    onehot = dcc_pkg::row_t'(1) << i;
  endfunction

  function automatic dcc_pkg::vid_t lowest(input dcc_pkg::row_t v);
    lowest = '0;
    for (int j = dcc_pkg::MAX_V - 1; j >= 0; j--) begin
      if (v[j]) lowest = dcc_pkg::vid_t'(j);
    end
  endfunction

  logic [3:0]          state_r, state_nxt;
  logic [dcc_pkg::REQ_W-1:0] req_r, req_nxt;
  dcc_pkg::vid_t       va_r, va_nxt, vb_r, vb_nxt;
  dcc_pkg::vid_t       keep_r, keep_nxt, old_r, old_nxt;
  dcc_pkg::vid_t       root_r, root_nxt, pidx_r, pidx_nxt;
  dcc_pkg::cnt_t       comps_r, comps_nxt, found_r, found_nxt, iss_r, iss_nxt;
  dcc_pkg::edge_cnt_t  edges_r, edges_nxt;
  dcc_pkg::row_t       visited_r, visited_nxt, reach_r, reach_nxt;
  dcc_pkg::row_t       pending_r, pending_nxt;
  logic                same_r, same_nxt, bad_r, bad_nxt, pend_r, pend_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic                o_same_r, o_same_nxt, o_bad_r, o_bad_nxt;
  dcc_pkg::cnt_t       o_comps_r, o_comps_nxt;
  dcc_pkg::edge_cnt_t  o_edges_r, o_edges_nxt;
  dcc_pkg::row_t       all_mask;
  dcc_pkg::row_t       grown;
  dcc_pkg::row_t       unvisited;
  dcc_pkg::vid_t       pick;
  logic                out_free;

  // Active vertex mask
  always_comb begin
    for (int j = 0; j < dcc_pkg::MAX_V; j++) begin
      all_mask[j] = (dcc_pkg::cnt_t'(j) < cfg.vin);
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free    = !out_vld_r || out_ch.ready;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    va_nxt      = va_r;
    vb_nxt      = vb_r;
    keep_nxt    = keep_r;
    old_nxt     = old_r;
    root_nxt    = root_r;
    pidx_nxt    = pidx_r;
    comps_nxt   = comps_r;
    found_nxt   = found_r;
    iss_nxt     = iss_r;
    edges_nxt   = edges_r;
    visited_nxt = visited_r;
    reach_nxt   = reach_r;
    pending_nxt = pending_r;
    same_nxt    = same_r;
    bad_nxt     = bad_r;
    pend_nxt    = pend_r;
    o_same_nxt  = o_same_r;
    o_bad_nxt   = o_bad_r;
    o_comps_nxt = o_comps_r;
    o_edges_nxt = o_edges_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;

    adj_cmd           = '0;
    adj_cmd.rd_addr   = va_r;
    lbl_cmd           = '0;
    lbl_cmd.rd_a_addr = va_r;
    lbl_cmd.rd_b_addr = vb_r;

    grown     = adj_row & all_mask & ~reach_r;
    unvisited = ~visited_r & all_mask;
    pick      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt = in_ch.req_type;
          va_nxt  = dcc_pkg::vid_t'(in_ch.vertex_a);
          vb_nxt  = dcc_pkg::vid_t'(in_ch.vertex_b);
          bad_nxt = (dcc_pkg::cnt_t'(in_ch.vertex_a) >= cfg.vin) ||
                    (dcc_pkg::cnt_t'(in_ch.vertex_b) >= cfg.vin);
          if (bad_nxt) begin
            same_nxt  = 1'b0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RDA;
          end
        end
      end
      // Row a and both labels are being read
      S_RDA: begin
        state_nxt = S_WRA;
      end
      // Update row a and the edge count; a query compares the labels instead
      S_WRA: begin
        keep_nxt = lbl_a;
        old_nxt  = lbl_b;
        if (req_r == dcc_pkg::REQ_INSERT) begin
          adj_cmd.wr_en   = 1'b1;
          adj_cmd.wr_addr = va_r;
          adj_cmd.wr_data = adj_row | onehot(vb_r);
          if (!adj_row[vb_r]) edges_nxt = edges_r + 1'b1;
          state_nxt = S_RDB;
        end else if (req_r == dcc_pkg::REQ_REMOVE) begin
          adj_cmd.wr_en   = 1'b1;
          adj_cmd.wr_addr = va_r;
          adj_cmd.wr_data = adj_row & ~onehot(vb_r);
          if (adj_row[vb_r]) edges_nxt = edges_r - 1'b1;
          state_nxt = S_RDB;
        end else begin
          same_nxt  = (lbl_a == lbl_b);
          state_nxt = S_FIN;
        end
      end
      S_RDB: begin
        adj_cmd.rd_addr = vb_r;
        state_nxt       = S_WRB;
      end
      // Update row b, then merge, relabel or finish
      S_WRB: begin
        adj_cmd.wr_en   = 1'b1;
        adj_cmd.wr_addr = vb_r;
        if (req_r == dcc_pkg::REQ_INSERT) begin
          adj_cmd.wr_data = adj_row | onehot(va_r);
          if (keep_r != old_r) begin
            comps_nxt = comps_r - 1'b1;
            iss_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_MRG;
          end else begin
            same_nxt  = 1'b1;
            state_nxt = S_FIN;
          end
        end else begin
          adj_cmd.wr_data = adj_row & ~onehot(va_r);
          visited_nxt     = '0;
          found_nxt       = '0;
          state_nxt       = S_RSEL;
        end
      end
      // Sweep labels: read one entry, rewrite the previous one if it matches
      S_MRG: begin
        lbl_cmd.rd_a_addr = iss_r[dcc_pkg::VID_W-1:0];
        if (iss_r < cfg.vin) begin
          iss_nxt  = iss_r + 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = iss_r[dcc_pkg::VID_W-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && (lbl_a == old_r)) begin
          lbl_cmd.wr_en   = 1'b1;
          lbl_cmd.wr_addr = pidx_r;
          lbl_cmd.wr_data = keep_r;
        end
        if (!pend_r && (iss_r >= cfg.vin)) begin
          same_nxt  = 1'b1;
          state_nxt = S_FIN;
        end
      end
      // Start a new component at the lowest unvisited vertex
      S_RSEL: begin
        if (unvisited == '0) begin
          comps_nxt = found_r;
          state_nxt = S_RDONE;
        end else begin
          pick        = lowest(unvisited);
          root_nxt    = pick;
          reach_nxt   = onehot(pick);
          pending_nxt = onehot(pick);
          found_nxt   = found_r + 1'b1;
          state_nxt   = S_REXP;
        end
      end
      // Expand one pending vertex: read its row, label it
      S_REXP: begin
        if (pending_r == '0) begin
          visited_nxt = visited_r | reach_r;
          state_nxt   = S_RSEL;
        end else begin
          pick            = lowest(pending_r);
          adj_cmd.rd_addr = pick;
          lbl_cmd.wr_en   = 1'b1;
          lbl_cmd.wr_addr = pick;
          lbl_cmd.wr_data = root_r;
          pending_nxt     = pending_r & ~onehot(pick);
          state_nxt       = S_RROW;
        end
      end
      // Add newly reached neighbors
      S_RROW: begin
        reach_nxt   = reach_r | grown;
        pending_nxt = pending_r | grown;
        state_nxt   = S_REXP;
      end
      S_RDONE: begin
        state_nxt = S_RSAME;
      end
      S_RSAME: begin
        same_nxt  = (lbl_a == lbl_b);
        state_nxt = S_FIN;
      end
      // Hand the result to the output register
      S_FIN: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          o_same_nxt  = same_r;
          o_bad_nxt   = bad_r;
          o_comps_nxt = comps_r;
          o_edges_nxt = edges_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Clear the graph on a vertex count write
    if (cfg.clr) begin
      comps_nxt = cfg.vin_new;
      edges_nxt = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
      comps_r   <= dcc_pkg::cnt_t'(dcc_pkg::MAX_V);
      edges_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      comps_r   <= comps_nxt;
      edges_r   <= edges_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    va_r      <= va_nxt;
    vb_r      <= vb_nxt;
    keep_r    <= keep_nxt;
    old_r     <= old_nxt;
    root_r    <= root_nxt;
    pidx_r    <= pidx_nxt;
    found_r   <= found_nxt;
    iss_r     <= iss_nxt;
    visited_r <= visited_nxt;
    reach_r   <= reach_nxt;
    pending_r <= pending_nxt;
    same_r    <= same_nxt;
    bad_r     <= bad_nxt;
    pend_r    <= pend_nxt;
    o_same_r  <= o_same_nxt;
    o_bad_r   <= o_bad_nxt;
    o_comps_r <= o_comps_nxt;
    o_edges_r <= o_edges_nxt;
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.same_component  = o_same_r;
  assign out_ch.component_count = o_comps_r;
  assign out_ch.edge_count      = o_edges_r;
  assign out_ch.bad_vertex      = o_bad_r;

endmodule

// ===== rtl/dynamic_connected_components.sv =====
// ----------------------------------------------------------------------------
// dynamic_connected_components
// Connected components of a 16-vertex undirected graph kept up to date
// under edge inserts and removals.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A query reads row a and both labels
// and goes to the result register; an insert also updates rows a and b,
// plus a label sweep when two components merge; a remove updates both
// rows and then searches for the components anew, reading one adjacency
// row per vertex from the row memory's single read port. A bad vertex
// number goes straight to the result state. The last cycle of an item
// repeats while the result register still holds an unread result. The
// result register lets the next item be accepted while a result waits.
// Reset and a write of the vertex count clear the graph at once through
// per-row valid bits; no clearing pass is needed. The vertex count
// register sits at byte address 0.
// ----------------------------------------------------------------------------
module dynamic_connected_components (
  input  logic                              clk,
  input  logic                              rst_n,
  dcc_in_if.sink                            in_ch,
  dcc_out_if.source                         out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [dcc_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  logic [dcc_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [dcc_pkg::APB_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  dcc_pkg::cnt_t     vin_r, vin_nxt;
  dcc_pkg::cnt_t     wr_val;
  logic              vin_wr;
  dcc_pkg::cfg_t     cfg;
  dcc_pkg::adj_cmd_t adj_cmd;
  dcc_pkg::lbl_cmd_t lbl_cmd;
  dcc_pkg::row_t     adj_row;
  dcc_pkg::vid_t     lbl_a;
  dcc_pkg::vid_t     lbl_b;

  // Register write decode and clamp
  assign vin_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[2] == dcc_pkg::REG_VIN);
  assign wr_val = cfg_pwdata[dcc_pkg::CNT_W-1:0];

  always_comb begin
    vin_nxt = vin_r;
    if (vin_wr) begin
      if (wr_val == '0) begin
        vin_nxt = dcc_pkg::cnt_t'(1);
      end else if (wr_val > dcc_pkg::cnt_t'(dcc_pkg::MAX_V)) begin
        vin_nxt = dcc_pkg::cnt_t'(dcc_pkg::MAX_V);
      end else begin
        vin_nxt = wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vin_r <= dcc_pkg::cnt_t'(dcc_pkg::MAX_V);
    end else begin
      vin_r <= vin_nxt;
    end
  end

  // Register read back
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == dcc_pkg::REG_VIN) ?
                      dcc_pkg::APB_DATA_W'(vin_r) : '0;

  assign cfg.clr     = vin_wr;
  assign cfg.vin     = vin_r;
  assign cfg.vin_new = vin_nxt;

  dcc_adj_mem u_adj_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (cfg.clr),
    .cmd    (adj_cmd),
    .rd_row (adj_row)
  );

  dcc_lbl_mem u_lbl_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (cfg.clr),
    .cmd   (lbl_cmd),
    .rd_a  (lbl_a),
    .rd_b  (lbl_b)
  );

  dcc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .adj_cmd (adj_cmd),
    .adj_row (adj_row),
    .lbl_cmd (lbl_cmd),
    .lbl_a   (lbl_a),
    .lbl_b   (lbl_b)
  );

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dynamic_connected_components. A graph model in the
// bench tracks edges, component labels and both counts; each accepted item
// updates the model and queues the result it should produce, and every result
// item is compared field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module tb;
  import dcc_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD    = 200;

  // Any code above the query code acts as a query
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  // Vertex count register address
  localparam logic [APB_ADDR_W-1:0] VIN_ADDR = {REG_VIN, 2'b00};

  typedef struct packed {
    logic      same_component;
    cnt_t      component_count;
    edge_cnt_t edge_count;
    logic      bad_vertex;
  } graph_result_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [APB_ADDR_W-1:0] cfg_paddr;
  logic [APB_DATA_W-1:0] cfg_pwdata;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  dcc_in_if  in_ch ();
  dcc_out_if out_ch ();

  dynamic_connected_components dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Graph model
  row_t      graph_rows [MAX_V];
  vid_t      vertex_label [MAX_V];
  cnt_t      component_total;
  edge_cnt_t edge_total;
  int        active_vertices;

  graph_result_t pending_results [$];
  graph_result_t got_result, want_result, new_result;

  int mismatches;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_request;

  always #(CLK_PERIOD/2) clk = ~clk;

  // Empty graph: no edges, every vertex alone
  function automatic void wipe_graph();
    for (int i = 0; i < MAX_V; i++) begin
      graph_rows[i]   = '0;
      vertex_label[i] = vid_t'(i);
    end
    component_total = cnt_t'(active_vertices);
    edge_total      = '0;
  endfunction

  // Label every component by the lowest vertex it holds
  function automatic void relabel_components();
    row_t active, seen, reach, grown;
    int   first;
    int   found;
    active = '0;
    seen   = '0;
    found  = 0;
    for (int i = 0; i < active_vertices; i++) active[i] = 1'b1;
    while ((seen & active) != active) begin
      first = 0;
      while (seen[first]) first++;
      reach = '0;
      reach[first] = 1'b1;
      // grow the reachable set until it stops changing
      forever begin
        grown = reach;
        for (int u = 0; u < active_vertices; u++)
          if (reach[u]) grown |= graph_rows[u] & active;
        if (grown == reach) break;
        reach = grown;
      end
      for (int u = 0; u < active_vertices; u++)
        if (reach[u]) vertex_label[u] = vid_t'(first);
      seen |= reach;
      found++;
    end
    component_total = cnt_t'(found);
  endfunction

  // Apply one request to the model and return the result it produces
  function automatic graph_result_t apply_graph_request(input logic [REQ_W-1:0] req,
                                                         input vid_t a, input vid_t b);
    graph_result_t res;
    vid_t keep, old;
    res = '0;
    if (a >= active_vertices || b >= active_vertices) begin
      res.bad_vertex = 1'b1;
    end else begin
      if (req == REQ_INSERT) begin
        keep = vertex_label[a];
        old  = vertex_label[b];
        if (keep != old) begin
          for (int i = 0; i < active_vertices; i++)
            if (vertex_label[i] == old) vertex_label[i] = keep;
          component_total--;
        end
        if (!graph_rows[a][b]) edge_total++;
        graph_rows[a][b] = 1'b1;
        graph_rows[b][a] = 1'b1;
      end else if (req == REQ_REMOVE) begin
        if (graph_rows[a][b]) edge_total--;
        graph_rows[a][b] = 1'b0;
        graph_rows[b][a] = 1'b0;
        relabel_components();
      end
      res.same_component = (vertex_label[a] == vertex_label[b]);
    end
    res.component_count = component_total;
    res.edge_count      = edge_total;
    return res;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_error($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // Check results against the queue, then log accepted items
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got_result.same_component  = out_ch.same_component;
        got_result.component_count = out_ch.component_count;
        got_result.edge_count      = out_ch.edge_count;
        got_result.bad_vertex      = out_ch.bad_vertex;
        if (pending_results.size() == 0) begin
          report_error("result item with no request pending");
        end else begin
          want_result = pending_results.pop_front();
          check_field("same_component", got_result.same_component,
                      want_result.same_component);
          check_field("component_count", got_result.component_count,
                      want_result.component_count);
          check_field("edge_count", got_result.edge_count, want_result.edge_count);
          check_field("bad_vertex", got_result.bad_vertex, want_result.bad_vertex);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        new_result = apply_graph_request(in_ch.req_type, in_ch.vertex_a, in_ch.vertex_b);
        pending_results.push_back(new_result);
      end
    end
  end

  // Drive ready: random stalls, or a long hold when asked
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic [REQ_W-1:0] req, input vid_t a, input vid_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.req_type <= req;
    in_ch.vertex_a <= a;
    in_ch.vertex_b <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Write the vertex count once the block is idle
  task automatic write_vertex_count(input logic [APB_DATA_W-1:0] value);
    logic [4:0] count;
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= VIN_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // zero reads as one, anything above the maximum as the maximum
    count = value[4:0];
    if (count == 0) active_vertices = 1;
    else if (count > MAX_V) active_vertices = MAX_V;
    else active_vertices = count;
    wipe_graph();
  endtask

  task automatic send_random_item();
    int               pick;
    int               ins_pct;
    logic [REQ_W-1:0] req;
    vid_t             a, b;
    // keep the graph sparse so removals can split components
    ins_pct = (edge_total > 2 * active_vertices) ? 25 : 45;
    pick = $urandom_range(99);
    if (pick < ins_pct) req = REQ_INSERT;
    else if (pick < ins_pct + 30) req = REQ_REMOVE;
    else if (pick < 95) req = REQ_QUERY;
    else req = REQ_UNKNOWN;
    // mostly in range, a few anywhere in the field
    if ($urandom_range(99) < 6) begin
      a = vid_t'($urandom_range(MAX_V - 1));
      b = vid_t'($urandom_range(MAX_V - 1));
    end else begin
      a = vid_t'($urandom_range(active_vertices - 1));
      b = vid_t'($urandom_range(active_vertices - 1));
    end
    // aim most removals at an edge that exists
    if (req == REQ_REMOVE && graph_rows[a] != '0 && $urandom_range(99) < 70) begin
      do b = vid_t'($urandom_range(MAX_V - 1)); while (!graph_rows[a][b]);
    end
    send_item(req, a, b);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_random_item();
  endtask

  // Inserts, merges, duplicates, self loops and removals from the reset graph
  task automatic test_reset_graph();
    send_item(REQ_QUERY, 4'd0, 4'd15);
    send_item(REQ_QUERY, 4'd7, 4'd7);
    send_item(REQ_INSERT, 4'd0, 4'd15);
    send_item(REQ_INSERT, 4'd0, 4'd15);
    send_item(REQ_INSERT, 4'd15, 4'd0);
    send_item(REQ_INSERT, 4'd5, 4'd5);
    send_item(REQ_INSERT, 4'd15, 4'd7);
    send_item(REQ_UNKNOWN, 4'd0, 4'd7);
    send_item(REQ_INSERT, 4'd8, 4'd9);
    send_item(REQ_INSERT, 4'd9, 4'd10);
    send_item(REQ_INSERT, 4'd10, 4'd0);
    send_item(REQ_REMOVE, 4'd0, 4'd15);
    send_item(REQ_REMOVE, 4'd0, 4'd15);
    send_item(REQ_REMOVE, 4'd5, 4'd5);
    send_item(REQ_REMOVE, 4'd3, 4'd12);
    send_item(REQ_QUERY, 4'd7, 4'd10);
  endtask

  // Vertex count extremes and out-of-range vertex numbers
  task automatic test_vertex_range();
    write_vertex_count(32'd0);
    send_item(REQ_INSERT, 4'd0, 4'd0);
    send_item(REQ_INSERT, 4'd0, 4'd1);
    send_item(REQ_REMOVE, 4'd1, 4'd0);
    send_item(REQ_QUERY, 4'd15, 4'd15);
    write_vertex_count(32'hFFFF_FFE3);
    send_item(REQ_INSERT, 4'd2, 4'd3);
    send_item(REQ_INSERT, 4'd0, 4'd2);
    send_item(REQ_REMOVE, 4'd3, 4'd3);
    write_vertex_count(32'd31);
    send_item(REQ_QUERY, 4'd0, 4'd15);
    write_vertex_count(32'd17);
    send_item(REQ_INSERT, 4'd15, 4'd15);
  endtask

  // Fill every edge of the largest graph, then strip one vertex
  task automatic test_full_graph();
    write_vertex_count(MAX_V);
    for (int i = 0; i < MAX_V; i++)
      for (int j = i; j < MAX_V; j++)
        if ($urandom_range(1)) send_item(REQ_INSERT, vid_t'(i), vid_t'(j));
        else send_item(REQ_INSERT, vid_t'(j), vid_t'(i));
    for (int j = 0; j < MAX_V; j++) send_item(REQ_REMOVE, 4'd0, vid_t'(j));
    send_item(REQ_QUERY, 4'd0, 4'd1);
  endtask

  // Hold off results for a long stretch while items keep coming
  task automatic test_output_stall();
    hold_request = 1'b1;
    test_random_traffic(16);
  endtask

  // Pause the sender until the block has drained
  task automatic test_sender_pause();
    test_random_traffic(10);
    wait_all_results();
    test_random_traffic(10);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_QUERY;
    in_ch.vertex_a = '0;
    in_ch.vertex_b = '0;
    out_ch.ready   = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    mismatches     = 0;
    cycle_count    = 0;
    hold_left      = 0;
    hold_request   = 1'b0;
    active_vertices = MAX_V;
    wipe_graph();
    set_idle(0, 0);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    set_idle(6, 81);
    test_reset_graph();
    test_vertex_range();
    test_full_graph();
    write_vertex_count(MAX_V);
    test_random_traffic(250);
    test_output_stall();

    set_idle(81, 6);
    write_vertex_count(($urandom() & 32'hFFFF_FFE0) | $urandom_range(2, 8));
    test_random_traffic(200);
    write_vertex_count(($urandom() & 32'hFFFF_FFE0) | $urandom_range(9, 15));
    test_random_traffic(150);
    test_sender_pause();

    set_idle(0, 0);
    write_vertex_count(32'd2);
    test_random_traffic(100);
    write_vertex_count(MAX_V);
    test_random_traffic(300);
    test_output_stall();

    // Drain, then watch for stray results
    wait_all_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) report_error("expected results left over");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== dynamic_connected_components.f =====
rtl/dcc_pkg.sv
rtl/dcc_intf.sv
rtl/dcc_adj_mem.sv
rtl/dcc_lbl_mem.sv
rtl/dcc_core.sv
rtl/dynamic_connected_components.sv
bench/tb.sv
